// ===== sv/eds_pkg.sv =====
// Shared constants and helpers for the 2D Euclidean distance block.
`default_nettype none

package eds_pkg;

	// Front stages: absolute difference, squaring, sum of squares.
	localparam int unsigned FRONT_STAGES = 3;

	// Number of root digits produced for a given coordinate width.
	function automatic int unsigned eds_root_bits(input int unsigned coord_width);
		return coord_width + 1;
	endfunction

	// Cycles from request acceptance to the result strobe.
	function automatic int unsigned eds_latency(input int unsigned coord_width);
		return FRONT_STAGES + eds_root_bits(coord_width);
	endfunction

endpackage

`default_nettype wire

// ===== sv/eds_sqrt_step.sv =====
// One registered digit step of the restoring square root pipeline.
`default_nettype none

module eds_sqrt_step #(
	parameter int unsigned ROOT_BITS = 17
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     valid_in,
	input  wire logic [2*ROOT_BITS-1:0]   rad_in,
	input  wire logic [ROOT_BITS-1:0]     root_in,
	input  wire logic [ROOT_BITS+1:0]     rem_in,
	output logic                          valid_q,
	output logic      [2*ROOT_BITS-1:0]   rad_q,
	output logic      [ROOT_BITS-1:0]     root_q,
	output logic      [ROOT_BITS+1:0]     rem_q
);

	import eds_pkg::*;

	logic [ROOT_BITS+1:0] rem_sh;
	logic [ROOT_BITS+1:0] trial;
	logic                 fits;

	// Remainder stays below 2^ROOT_BITS before the shift, so its top bits drop out.
	assign rem_sh = {rem_in[ROOT_BITS-1:0], rad_in[2*ROOT_BITS-1 -: 2]};
	assign trial  = {root_in, 2'b01};
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= {rad_in[2*ROOT_BITS-3:0], 2'b00};
		root_q <= {root_in[ROOT_BITS-2:0], fits};
		rem_q  <= fits ? (rem_sh - trial) : rem_sh;
	end

endmodule

`default_nettype wire

// ===== sv/euclidean_distance_2d_top.sv =====
// Top level of the pipelined 2D Euclidean distance block.
//
// Request channel: origin_x, origin_y, target_x, target_y are signed
// coordinates. A request is taken on a rising edge with start high and
// busy low. busy is high only while arst_n holds the block in reset and
// drops on the first edge after release; from then on a request may be
// issued on every cycle.
// Result channel: distance = floor(sqrt(dx^2 + dy^2)), shown for one cycle
// with done high. Results come out in request order.
// On its way from acceptance to the done cycle, a request passes through
// one stage each for the absolute differences, the squares and their sum,
// then through one stage per root digit.
// Throughput: one request per cycle, set by the fully pipelined digit
// chain. The receiver cannot stall; every result is presented exactly once.
// Reset clears all valid bits, so nothing in flight survives it.
`default_nettype none

module euclidean_distance_2d_top #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [COORD_WIDTH-1:0] origin_x,
	input  wire logic signed [COORD_WIDTH-1:0] origin_y,
	input  wire logic signed [COORD_WIDTH-1:0] target_x,
	input  wire logic signed [COORD_WIDTH-1:0] target_y,
	output logic                               done,
	output logic             [COORD_WIDTH:0]   distance
);

	import eds_pkg::*;

	localparam int unsigned W  = COORD_WIDTH;
	localparam int unsigned RB = eds_root_bits(COORD_WIDTH);

	logic busy_q;
	logic accept;

	logic signed [W:0] diff_x;
	logic signed [W:0] diff_y;
	logic        [W:0] mag_x;
	logic        [W:0] mag_y;

	logic              valid_s1;
	logic [W-1:0]      adx_s1;
	logic [W-1:0]      ady_s1;
	logic              valid_s2;
	logic [2*W-1:0]    sqx_s2;
	logic [2*W-1:0]    sqy_s2;
	logic              valid_s3;
	logic [2*W:0]      sum_s3;

	logic               step_valid [RB+1];
	logic [2*RB-1:0]    step_rad   [RB+1];
	logic [RB-1:0]      step_root  [RB+1];
	logic [RB+1:0]      step_rem   [RB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	assign diff_x = {origin_x[W-1], origin_x} - {target_x[W-1], target_x};
	assign diff_y = {origin_y[W-1], origin_y} - {target_y[W-1], target_y};
	assign mag_x  = diff_x[W] ? (~diff_x + 1'b1) : diff_x;
	assign mag_y  = diff_y[W] ? (~diff_y + 1'b1) : diff_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Magnitudes never exceed 2^W - 1, so the top bit is always clear.
	always_ff @(posedge clk) begin
		adx_s1 <= mag_x[W-1:0];
		ady_s1 <= mag_y[W-1:0];
		sqx_s2 <= adx_s1 * adx_s1;
		sqy_s2 <= ady_s1 * ady_s1;
		sum_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
	end

	assign step_valid[0] = valid_s3;
	assign step_rad[0]   = {1'b0, sum_s3};
	assign step_root[0]  = '0;
	assign step_rem[0]   = '0;

	for (genvar i = 0; i < RB; i++) begin : g_step
		eds_sqrt_step #(
			.ROOT_BITS (RB)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (step_valid[i]),
			.rad_in   (step_rad[i]),
			.root_in  (step_root[i]),
			.rem_in   (step_rem[i]),
			.valid_q  (step_valid[i+1]),
			.rad_q    (step_rad[i+1]),
			.root_q   (step_root[i+1]),
			.rem_q    (step_rem[i+1])
		);
	end

	assign done     = step_valid[RB];
	assign distance = step_root[RB];

endmodule

`default_nettype wire

// ===== sv/eds_checker.sv =====
// Port-level assertions for the Euclidean distance block, bound to the top level.
`default_nettype none

module eds_checker #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic signed [COORD_WIDTH-1:0] origin_x,
	input wire logic signed [COORD_WIDTH-1:0] origin_y,
	input wire logic signed [COORD_WIDTH-1:0] target_x,
	input wire logic signed [COORD_WIDTH-1:0] target_y,
	input wire logic                          done,
	input wire logic        [COORD_WIDTH:0]   distance
);

	import eds_pkg::*;

	localparam int unsigned W   = COORD_WIDTH;
	localparam int unsigned LAT = eds_latency(COORD_WIDTH);

	logic              accept;
	logic signed [W:0] diff_x;
	logic        [W:0] mag_x;

	assign accept = start && !busy;
	assign diff_x = {origin_x[W-1], origin_x} - {target_x[W-1], target_x};
	assign mag_x  = diff_x[W] ? (~diff_x + 1'b1) : diff_x;

	// busy only covers reset
	a_busy_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> !busy)
		else $error("busy high outside reset");

	// exactly one strobe per accepted request, at fixed latency;
	// history from before the first edge counts as no request
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == ($past(accept, LAT) === 1'b1))
		else $error("result strobe does not match request latency");

	// identical points give zero distance
	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		$past(accept && origin_x == target_x && origin_y == target_y, LAT)
		|-> distance == '0)
		else $error("nonzero distance for identical points");

	// on a horizontal line the root is exactly the X magnitude
	a_axis_dist: assert property (@(posedge clk) disable iff (!arst_n)
		$past(accept && origin_y == target_y, LAT) |-> distance == $past(mag_x, LAT))
		else $error("axis distance mismatch");

endmodule

bind euclidean_distance_2d_top eds_checker #(.COORD_WIDTH(COORD_WIDTH)) u_eds_checker (.*);

`default_nettype wire

// ===== tb/sv/eds_distance_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the 2D Euclidean distance block: predicts each distance and checks the results.
module eds_distance_checker #(
	parameter int unsigned CW = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire logic signed [CW-1:0] origin_x,
	input  wire logic signed [CW-1:0] origin_y,
	input  wire logic signed [CW-1:0] target_x,
	input  wire logic signed [CW-1:0] target_y,
	input  wire logic                 done,
	input  wire logic        [CW:0]   distance,
	output int unsigned               fail_count = 0,
	output int unsigned               pending = 0
);

	logic [CW:0] expected_distance_q[$];
	logic [CW:0] oldest_distance;

	// Restoring digit-by-digit square root, two radicand bits per digit.
	function automatic logic [CW:0] floor_root(input logic [2*CW+1:0] radicand);
		logic [2*CW+3:0] rem;
		logic [2*CW+3:0] trial;
		logic [CW:0]     root;
		int              k;
		rem  = '0;
		root = '0;
		for (k = CW; k >= 0; k--) begin
			rem   = (rem << 2) | radicand[2*k +: 2];
			trial = ({{(CW+3){1'b0}}, root} << 2) | 1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = {root[CW-1:0], 1'b1};
			end else begin
				root = {root[CW-1:0], 1'b0};
			end
		end
		return root;
	endfunction

	function automatic logic [CW:0] predict_distance(input logic signed [CW-1:0] ox,
			input logic signed [CW-1:0] oy, input logic signed [CW-1:0] tx,
			input logic signed [CW-1:0] ty);
		logic signed [CW:0] dx;
		logic signed [CW:0] dy;
		logic [2*CW+1:0]    mag_x;
		logic [2*CW+1:0]    mag_y;
		// differences at one extra bit so extreme coordinates cannot wrap
		dx    = {ox[CW-1], ox} - {tx[CW-1], tx};
		dy    = {oy[CW-1], oy} - {ty[CW-1], ty};
		mag_x = dx[CW] ? -dx : dx;
		mag_y = dy[CW] ? -dy : dy;
		return floor_root(mag_x * mag_x + mag_y * mag_y);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_distance_q.size() == 0) begin
					$error("distance: unexpected result, actual %0d", distance);
					fail_count++;
				end else begin
					oldest_distance = expected_distance_q.pop_front();
					if (distance !== oldest_distance) begin
						$error("distance: expected %0d, actual %0d", oldest_distance, distance);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				expected_distance_q.push_back(predict_distance(origin_x, origin_y,
					target_x, target_y));
		end
		pending <= expected_distance_q.size();
	end

endmodule

// ===== tb/sv/tb_euclidean_distance_2d_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the 2D Euclidean distance block: clock, reset, request stimulus and verdict.
module tb_euclidean_distance_2d_top;
	import eds_pkg::*;

	localparam int unsigned COORD_WIDTH     = 16;
	localparam int unsigned LATENCY         = eds_latency(COORD_WIDTH);
	localparam int unsigned RANDOM_REQUESTS = 800;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          start    = 1'b0;
	logic signed [COORD_WIDTH-1:0] origin_x = '0;
	logic signed [COORD_WIDTH-1:0] origin_y = '0;
	logic signed [COORD_WIDTH-1:0] target_x = '0;
	logic signed [COORD_WIDTH-1:0] target_y = '0;
	wire logic                     busy;
	wire logic                     done;
	wire logic   [COORD_WIDTH:0]   distance;
	int unsigned                   fail_count;
	int unsigned                   pending;
	int                            burst_left = 0;

	euclidean_distance_2d_top #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.target_x(target_x),
		.target_y(target_y),
		.done(done),
		.distance(distance)
	);

	eds_distance_checker #(
		.CW(COORD_WIDTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.target_x(target_x),
		.target_y(target_y),
		.done(done),
		.distance(distance),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Holds the request until an edge takes it (start high, busy low).
	task automatic issue_point_pair(input logic [COORD_WIDTH-1:0] ox,
			input logic [COORD_WIDTH-1:0] oy, input logic [COORD_WIDTH-1:0] tx,
			input logic [COORD_WIDTH-1:0] ty);
		start    <= 1'b1;
		origin_x <= ox;
		origin_y <= oy;
		target_x <= tx;
		target_y <= ty;
		do @(posedge clk); while (busy);
	endtask

	// Bursts of back-to-back requests separated by idle gaps of random length.
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 25 : 4)) @(posedge clk);
			burst_left = $urandom_range(0, 40);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic run_pair(input int ox, input int oy, input int tx, input int ty);
		issue_point_pair(ox[COORD_WIDTH-1:0], oy[COORD_WIDTH-1:0],
			tx[COORD_WIDTH-1:0], ty[COORD_WIDTH-1:0]);
		pace_sender();
	endtask

	function automatic logic [COORD_WIDTH-1:0] pick_extreme();
		case ($urandom_range(0, 5))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			4:       return 16'h8001;
			default: return 16'h0001;
		endcase
	endfunction

	initial begin
		logic [COORD_WIDTH-1:0] ox;
		logic [COORD_WIDTH-1:0] oy;
		logic [COORD_WIDTH-1:0] tx;
		logic [COORD_WIDTH-1:0] ty;
		int                     i;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coincident points, extremes, single-axis cases, rounding
		run_pair(0, 0, 0, 0);
		run_pair(-32768, -32768, 32767, 32767);
		run_pair(32767, 32767, -32768, -32768);
		run_pair(32767, -32768, -32768, 32767);
		run_pair(-32768, 32767, 32767, -32768);
		run_pair(-32768, 0, 32767, 0);
		run_pair(0, 32767, 0, -32768);
		run_pair(-32768, -32768, -32768, -32768);
		run_pair(32767, 32767, 32767, 32767);
		run_pair(1234, -500, 1234, 700);
		run_pair(-900, 42, 300, 42);
		run_pair(0, 0, 3, 4);
		run_pair(0, 0, 1, 1);
		run_pair(0, 0, 1, 2);
		run_pair(-1, -1, 0, 0);
		run_pair(0, 0, -1, -1);
		run_pair(-1, 0, 0, 0);
		run_pair(0, -32768, 0, 0);
		run_pair(-32768, -32768, 0, 0);
		run_pair(32767, 0, -32768, -32768);
		run_pair(100, 200, -100, -200);
		issue_point_pair(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
		drain_results();

		for (i = 0; i < RANDOM_REQUESTS; i++) begin
			ox = COORD_WIDTH'($urandom());
			oy = COORD_WIDTH'($urandom());
			tx = COORD_WIDTH'($urandom());
			ty = COORD_WIDTH'($urandom());
			case ($urandom_range(0, 4))
				1: begin
					tx = COORD_WIDTH'(ox + $urandom_range(0, 64) - 32);
					ty = COORD_WIDTH'(oy + $urandom_range(0, 64) - 32);
				end
				2: begin
					ox = pick_extreme();
					oy = pick_extreme();
					tx = pick_extreme();
					ty = pick_extreme();
				end
				3: begin
					if ($urandom_range(0, 1)) tx = ox;
					else ty = oy;
				end
				4: begin
					ox = COORD_WIDTH'($urandom_range(0, 400) - 200);
					oy = COORD_WIDTH'($urandom_range(0, 400) - 200);
					tx = COORD_WIDTH'($urandom_range(0, 400) - 200);
					ty = COORD_WIDTH'($urandom_range(0, 400) - 200);
				end
				default: ;
			endcase
			issue_point_pair(ox, oy, tx, ty);
			if (i == RANDOM_REQUESTS / 2)
				drain_results();
			else
				pace_sender();
		end

		drain_results();
		repeat (LATENCY + 4) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
sv/eds_pkg.sv
sv/eds_sqrt_step.sv
sv/euclidean_distance_2d_top.sv
sv/eds_checker.sv
tb/sv/eds_distance_checker.sv
tb/sv/tb_euclidean_distance_2d_top.sv
